// ----- hw/rtl/knps_pkg.sv -----
// knps_pkg: shared types, constants and helpers of the k-nearest point selector
// used by every module under hw/rtl except knps_ram; depends on nothing
package knps_pkg;

   localparam int MAX_NEIGHBORS = 16;
   localparam int COORD_W       = 16;
   localparam int DIST_W        = 36;
   localparam int NC_W          = 5;
   localparam int IDX_W         = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int SIZE_W        = $clog2(MAX_NEIGHBORS + 1);
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   typedef enum logic [1:0] {
      REG_NEIGHBOR_COUNT = 2'd0,
      REG_GOAL_X         = 2'd1,
      REG_GOAL_Y         = 2'd2,
      REG_GOAL_Z         = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIST1,
      ST_DIST2,
      ST_DIST3,
      ST_CHECK,
      ST_SEEK,
      ST_SHIFT,
      ST_WORST,
      ST_STAT,
      ST_STATUS_OUT,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      point_type          pos;
      logic [DIST_W-1:0]  dist_sq;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [NC_W-1:0]           neighbor_count;
      logic signed [COORD_W-1:0] goal_x;
      logic signed [COORD_W-1:0] goal_y;
      logic signed [COORD_W-1:0] goal_z;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      restart;
      logic                      final_point;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic                      filled;
      logic [DIST_W-1:0]         worst_distance;
      logic                      list_entry;
      logic signed [COORD_W-1:0] entry_x;
      logic signed [COORD_W-1:0] entry_y;
      logic signed [COORD_W-1:0] entry_z;
      logic [DIST_W-1:0]         entry_distance;
      logic                      last;
   } rsp_type;

   // neighbor count of zero acts as one, above the capacity acts as the capacity
   function automatic logic [SIZE_W-1:0] active_k(input logic [NC_W-1:0] nc);
      logic [SIZE_W-1:0] k;
      if (nc == '0) begin
         k = SIZE_W'(1);
      end else if (int'(nc) > MAX_NEIGHBORS) begin
         k = SIZE_W'(MAX_NEIGHBORS);
      end else begin
         k = SIZE_W'(nc);
      end
      return k;
   endfunction

endpackage

// ----- hw/rtl/k_nearest_point_selector_top.sv -----
// k_nearest_point_selector_top: top level of the k-nearest point selector
// depends on knps_pkg, knps_cfg, knps_dist, knps_ctrl (and knps_ram below it)
//
// Usage:
//   The req channel carries one candidate point per beat, with restart (empty the
//   kept list first) and final_point (read the list out afterwards). The rsp channel
//   gives one status beat per ordinary point, or one beat per kept entry, best first,
//   for a final point, with last on the closing beat.
//   The apb port holds neighbor_count (0x0) and goal_x/y/z (0x4, 0x8, 0xc); write it
//   only while the block is idle.
//   Sequence: a rejected point passes three distance stages, compare, worst read
//   and status load before its status beat appears, and the next req beat can be
//   taken while that beat is presented. An accepted point places itself between
//   compare and worst read: each kept entry that moves down the list is read and
//   rewritten one place further down, and the point is written at the head or, after
//   reading an entry no worse than itself, just below it. A final point reads each
//   kept entry from the ram (registered read) before loading it as a list beat.
//   One item is worked on at a time; req_stall is low only between items. A status
//   beat waiting in the output register does not hold off the next item.
//   When rsp_stall is high while a beat is valid, the output register holds it and the sequencer
//   waits before loading the next one.
//   Reset empties the kept list, sets neighbor_count to 1 and the goal to the origin;
//   the ram itself is not cleared.
module k_nearest_point_selector_top
   import knps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type           cfg;
   point_type         point;
   logic [DIST_W-1:0] cand_dist;

   knps_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   knps_dist u_dist (
      .clock     (clock),
      .point     (point),
      .cfg       (cfg),
      .cand_dist (cand_dist)
   );

   knps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .point     (point),
      .cand_dist (cand_dist)
   );

endmodule

// ----- hw/rtl/knps_ram.sv -----
// knps_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module knps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/knps_cfg.sv -----
// knps_cfg: apb register file holding the neighbor count and goal point
// depends on knps_pkg
module knps_cfg
   import knps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_strobe;

   assign reg_sel   = reg_index_type'(paddr[3:2]);
   assign pready    = 1'b1;
   assign wr_strobe = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         unique case (reg_sel)
            REG_NEIGHBOR_COUNT: cfg_in.neighbor_count = pwdata[NC_W-1:0];
            REG_GOAL_X:         cfg_in.goal_x = pwdata[COORD_W-1:0];
            REG_GOAL_Y:         cfg_in.goal_y = pwdata[COORD_W-1:0];
            REG_GOAL_Z:         cfg_in.goal_z = pwdata[COORD_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_NEIGHBOR_COUNT: prdata = CSR_DATA_W'(cfg_ff.neighbor_count);
         REG_GOAL_X:         prdata = CSR_DATA_W'(signed'(cfg_ff.goal_x));
         REG_GOAL_Y:         prdata = CSR_DATA_W'(signed'(cfg_ff.goal_y));
         REG_GOAL_Z:         prdata = CSR_DATA_W'(signed'(cfg_ff.goal_z));
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neighbor_count <= NC_W'(1);
         cfg_ff.goal_x         <= '0;
         cfg_ff.goal_y         <= '0;
         cfg_ff.goal_z         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/knps_dist.sv -----
// knps_dist: three-stage squared euclidean distance pipeline
// depends on knps_pkg
module knps_dist
   import knps_pkg::*;
(
   input  logic              clock,
   input  point_type         point,
   input  cfg_type           cfg,
   output logic [DIST_W-1:0] cand_dist
);

   logic signed [COORD_W:0]   dx, dy, dz;
   logic [COORD_W:0]          mx, my, mz;
   logic [COORD_W-1:0]        ax_ff, ay_ff, az_ff;
   logic [2*COORD_W-1:0]      sx_ff, sy_ff, sz_ff;
   logic [DIST_W-1:0]         dist_ff;

   always_comb begin
      dx = {point.x[COORD_W-1], point.x} - {cfg.goal_x[COORD_W-1], cfg.goal_x};
      dy = {point.y[COORD_W-1], point.y} - {cfg.goal_y[COORD_W-1], cfg.goal_y};
      dz = {point.z[COORD_W-1], point.z} - {cfg.goal_z[COORD_W-1], cfg.goal_z};
      mx = dx[COORD_W] ? (~dx + (COORD_W+1)'(1)) : dx;
      my = dy[COORD_W] ? (~dy + (COORD_W+1)'(1)) : dy;
      mz = dz[COORD_W] ? (~dz + (COORD_W+1)'(1)) : dz;
   end

   always_ff @(posedge clock) begin
      ax_ff   <= mx[COORD_W-1:0];
      ay_ff   <= my[COORD_W-1:0];
      az_ff   <= mz[COORD_W-1:0];
      sx_ff   <= ax_ff * ax_ff;
      sy_ff   <= ay_ff * ay_ff;
      sz_ff   <= az_ff * az_ff;
      dist_ff <= DIST_W'(sx_ff) + DIST_W'(sy_ff) + DIST_W'(sz_ff);
   end

   assign cand_dist = dist_ff;

endmodule

// ----- hw/rtl/knps_ctrl.sv -----
// knps_ctrl: sequencer for sorted insertion into the kept-entry ram and list readout
// depends on knps_pkg and knps_ram
module knps_ctrl
   import knps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   output point_type         point,
   input  logic [DIST_W-1:0] cand_dist
);

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  emit_ff, emit_in;
   logic              accepted_ff, accepted_in;
   logic              final_ff, final_in;
   logic [DIST_W-1:0] worst_ff, worst_in;
   point_type         point_ff, point_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              rd_en, wr_en;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   entry_type         wr_data, rd_data;
   entry_type         new_entry;
   logic [SIZE_W-1:0] k_eff;
   logic [SIZE_W-1:0] size_m1;
   logic              out_free, rsp_load, last_entry;

   knps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_NEIGHBORS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign k_eff      = active_k(cfg.neighbor_count);
   assign size_m1    = size_ff - SIZE_W'(1);
   assign new_entry  = '{pos: point_ff, dist_sq: cand_dist};
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign last_entry = (SIZE_W'(emit_ff) + SIZE_W'(1)) == size_ff;
   assign point      = point_ff;

   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      cur_in      = cur_ff;
      emit_in     = emit_ff;
      accepted_in = accepted_ff;
      final_in    = final_ff;
      worst_in    = worst_ff;
      point_in    = point_ff;
      req_stall   = 1'b1;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = new_entry;
      rsp_load    = 1'b0;
      rsp_in      = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               point_in = '{x: req_data.point_x, y: req_data.point_y, z: req_data.point_z};
               final_in = req_data.final_point;
               if (req_data.restart) begin
                  size_in = '0;
               end
               state_in = ST_DIST1;
            end
         end
         ST_DIST1: begin
            // fetch the current worst entry while the distance is computed
            rd_en    = (size_ff != '0);
            rd_addr  = size_m1[IDX_W-1:0];
            state_in = ST_DIST2;
         end
         ST_DIST2: begin
            state_in = ST_DIST3;
         end
         ST_DIST3: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ((size_ff < k_eff) && (size_ff < SIZE_W'(MAX_NEIGHBORS))) begin
               accepted_in = 1'b1;
               cur_in      = size_ff[IDX_W-1:0];
               size_in     = size_ff + SIZE_W'(1);
               state_in    = ST_SEEK;
            end else if ((size_ff != '0) && (cand_dist < rd_data.dist_sq)) begin
               // drop the worst entry, size stays
               accepted_in = 1'b1;
               cur_in      = size_m1[IDX_W-1:0];
               state_in    = ST_SEEK;
            end else begin
               accepted_in = 1'b0;
               state_in    = ST_WORST;
            end
         end
         ST_SEEK: begin
            if (cur_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff;
               state_in = ST_WORST;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cur_ff - IDX_W'(1);
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            if (rd_data.dist_sq > cand_dist) begin
               wr_data  = rd_data;
               cur_in   = cur_ff - IDX_W'(1);
               state_in = ST_SEEK;
            end else begin
               state_in = ST_WORST;
            end
         end
         ST_WORST: begin
            rd_en    = (size_ff != '0);
            rd_addr  = size_m1[IDX_W-1:0];
            state_in = ST_STAT;
         end
         ST_STAT: begin
            worst_in = (size_ff != '0) ? rd_data.dist_sq : '0;
            emit_in  = '0;
            state_in = (final_ff && (size_ff != '0)) ? ST_READ : ST_STATUS_OUT;
         end
         ST_STATUS_OUT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = '{accepted: accepted_ff, filled: (size_ff >= k_eff),
                            worst_distance: worst_ff, list_entry: 1'b0,
                            entry_x: '0, entry_y: '0, entry_z: '0,
                            entry_distance: '0, last: 1'b1};
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = emit_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = '{accepted: accepted_ff, filled: (size_ff >= k_eff),
                            worst_distance: worst_ff, list_entry: 1'b1,
                            entry_x: rd_data.pos.x, entry_y: rd_data.pos.y,
                            entry_z: rd_data.pos.z, entry_distance: rd_data.dist_sq,
                            last: last_entry};
               emit_in  = emit_ff + IDX_W'(1);
               state_in = last_entry ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      emit_ff     <= emit_in;
      accepted_ff <= accepted_in;
      final_ff    <= final_in;
      worst_ff    <= worst_in;
      point_ff    <= point_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      int'(size_ff) <= MAX_NEIGHBORS)
      else $error("kept size above capacity");

   a_write_below_size: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (SIZE_W'(wr_addr) < size_ff))
      else $error("ram write outside kept list");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("ram read and write of the same entry");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.list_entry) |-> rsp_ff.last)
      else $error("status beat without last");

   a_no_load_while_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("output register overwritten while stalled");

endmodule
